[rtl/ssd_pkg.sv]
// Shared types, command codes and lookup functions of the seven-segment display controller.
`default_nettype none

package ssd_pkg;

  localparam int NUM_DIGITS = 6;

  localparam logic [2:0] OP_CLEAR_ALL  = 3'd0;
  localparam logic [2:0] OP_CLEAR_DOTS = 3'd1;
  localparam logic [2:0] OP_DOT        = 3'd2;
  localparam logic [2:0] OP_NIBBLE     = 3'd3;
  localparam logic [2:0] OP_BYTE       = 3'd4;
  localparam logic [2:0] OP_HALFWORD   = 3'd5;
  localparam logic [2:0] OP_DECIMAL    = 3'd6;

  localparam logic [7:0] BLANK = 8'hFF;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  start_digit;
    logic [3:0]  digit_count;
    logic [2:0]  point_position;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] digit0_segments;
    logic [7:0] digit1_segments;
    logic [7:0] digit2_segments;
    logic [7:0] digit3_segments;
    logic [7:0] digit4_segments;
    logic [7:0] digit5_segments;
    logic [7:0] dot_mask;
  } out_item_t;

  // Active-low segment pattern of a hex digit, bit7 kept high.
  function automatic logic [7:0] seg_pattern(input logic [3:0] nib);
    logic [7:0] pat;
    unique case (nib)
      4'h0: pat = 8'hC0;
      4'h1: pat = 8'hF9;
      4'h2: pat = 8'hA4;
      4'h3: pat = 8'hB0;
      4'h4: pat = 8'h99;
      4'h5: pat = 8'h92;
      4'h6: pat = 8'h82;
      4'h7: pat = 8'hF8;
      4'h8: pat = 8'h80;
      4'h9: pat = 8'h90;
      4'hA: pat = 8'h88;
      4'hB: pat = 8'h83;
      4'hC: pat = 8'hC6;
      4'hD: pat = 8'hA1;
      4'hE: pat = 8'h86;
      4'hF: pat = 8'h8E;
    endcase
    return pat;
  endfunction

  // Largest number of n decimal digits.
  function automatic logic [31:0] pow10m1(input logic [3:0] n);
    logic [31:0] lim;
    unique case (n)
      4'd0:    lim = 32'd0;
      4'd1:    lim = 32'd9;
      4'd2:    lim = 32'd99;
      4'd3:    lim = 32'd999;
      4'd4:    lim = 32'd9999;
      4'd5:    lim = 32'd99999;
      4'd6:    lim = 32'd999999;
      4'd7:    lim = 32'd9999999;
      4'd8:    lim = 32'd99999999;
      4'd9:    lim = 32'd999999999;
      default: lim = 32'hFFFF_FFFF;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

[rtl/seven_segment_display_controller_top.sv]
// Six-digit seven-segment display controller: command sequencer, binary-to-BCD unit, registers.
`default_nettype none

// Each item is one display command; the block answers it with a single out_valid pulse
// that carries all six segment registers and the dot register, and the receiver has to
// take it in that cycle. Clear, dot and hex commands are carried out in the S_DISPATCH
// state, which raises the pulse. For a decimal command the value is clamped to the
// digit count, then a shift-and-add-3 binary-to-BCD unit converts it one bit per cycle
// (VAL_W bits, enough for the largest DIGIT_COUNT_MAX-digit number), and the digits are
// written in the S_WRITE state, which raises the pulse. busy is high from the accepting
// edge until the result pulse; a new item may be taken during the pulse.
module seven_segment_display_controller_top #(
  parameter int DIGIT_COUNT_MAX = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ssd_pkg::in_item_t in_item,
  output logic                   out_valid,
  output ssd_pkg::out_item_t     out_item
);

  import ssd_pkg::*;

  localparam int VAL_W = $clog2(pow10m1(4'(DIGIT_COUNT_MAX)) + 32'd1);
  localparam int BCD_W = DIGIT_COUNT_MAX * 4;
  localparam int CNT_W = $clog2(VAL_W + 1);
  localparam logic [3:0] DCM_L = 4'(DIGIT_COUNT_MAX);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_CONV,
    S_WRITE
  } state_t;

  state_t            state_r;
  logic              out_valid_r;
  logic [7:0]        dig_r [NUM_DIGITS];
  logic [7:0]        dot_r;
  logic [2:0]        op_r;
  logic [2:0]        start_r;
  logic [3:0]        count_r;
  logic [2:0]        point_r;
  logic [31:0]       value_r;
  logic [VAL_W-1:0]  bin_r;
  logic [BCD_W-1:0]  bcd_r;
  logic [CNT_W-1:0]  bits_r;

  logic [3:0]             cnt_in;
  logic [31:0]            limit;
  logic [31:0]            sat;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BCD_W+VAL_W-1:0] shift_nxt;
  logic [7:0]             hex_pat [NUM_DIGITS];
  logic [NUM_DIGITS-1:0]  hex_wr;
  logic [7:0]             dec_pat [NUM_DIGITS];
  logic [NUM_DIGITS-1:0]  dec_wr;
  logic [NUM_DIGITS-1:0]  dec_dot;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  assign out_item.digit0_segments = dig_r[0];
  assign out_item.digit1_segments = dig_r[1];
  assign out_item.digit2_segments = dig_r[2];
  assign out_item.digit3_segments = dig_r[3];
  assign out_item.digit4_segments = dig_r[4];
  assign out_item.digit5_segments = dig_r[5];
  assign out_item.dot_mask        = dot_r;

  assign cnt_in = (in_item.digit_count > DCM_L) ? DCM_L : in_item.digit_count;

  // Saturate to all nines of the requested width.
  assign limit = pow10m1(count_r);
  assign sat   = (value_r > limit) ? limit : value_r;

  // One shift-and-add-3 step of the BCD unit.
  always_comb begin
    for (int j = 0; j < DIGIT_COUNT_MAX; j++) begin
      if (bcd_r[j*4 +: 4] >= 4'd5) begin
        bcd_adj[j*4 +: 4] = bcd_r[j*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[j*4 +: 4] = bcd_r[j*4 +: 4];
      end
    end
    shift_nxt = {bcd_adj, bin_r} << 1;
  end

  // Hex commands: digit p shows nibble (p - start) counted from the most significant one.
  always_comb begin
    logic [4:0] off;
    logic [4:0] n;
    logic [3:0] nib;
    for (int p = 0; p < NUM_DIGITS; p++) begin
      off = 5'(p) - {2'b00, start_r};
      unique case (op_r)
        OP_NIBBLE:   n = 5'd1;
        OP_BYTE:     n = 5'd2;
        OP_HALFWORD: n = 5'd4;
        default:     n = 5'd0;
      endcase
      hex_wr[p] = (5'(p) >= {2'b00, start_r}) && (off < n);
      unique case (op_r)
        OP_BYTE:     nib = off[0] ? value_r[3:0] : value_r[7:4];
        OP_HALFWORD: begin
          unique case (off[1:0])
            2'd0: nib = value_r[15:12];
            2'd1: nib = value_r[11:8];
            2'd2: nib = value_r[7:4];
            2'd3: nib = value_r[3:0];
          endcase
        end
        default:     nib = value_r[3:0];
      endcase
      if (op_r == OP_NIBBLE && value_r > 32'd15) begin
        hex_pat[p] = BLANK;
      end else begin
        hex_pat[p] = seg_pattern(nib);
      end
    end
  end

  // Decimal write-back: digits fill from the right end of the covered span.
  always_comb begin
    logic [4:0] span_end;
    logic [4:0] idx;
    logic [3:0] dsel;
    span_end = {2'b00, start_r} + {1'b0, count_r};
    for (int p = 0; p < NUM_DIGITS; p++) begin
      idx  = span_end - 5'd1 - 5'(p);
      dsel = 4'd0;
      for (int j = 0; j < DIGIT_COUNT_MAX; j++) begin
        if (idx == 5'(j)) begin
          dsel = bcd_r[j*4 +: 4];
        end
      end
      dec_wr[p]  = (5'(p) >= {2'b00, start_r}) && (5'(p) < span_end);
      dec_pat[p] = seg_pattern(dsel);
      dec_dot[p] = (idx != {2'b00, point_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int p = 0; p < NUM_DIGITS; p++) begin
        dig_r[p] <= BLANK;
      end
      dot_r <= BLANK;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            op_r    <= in_item.operation;
            start_r <= in_item.start_digit;
            count_r <= cnt_in;
            point_r <= in_item.point_position;
            value_r <= in_item.value;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          priority if (op_r == OP_DECIMAL && count_r != 4'd0) begin
            bin_r       <= sat[VAL_W-1:0];
            bcd_r       <= '0;
            bits_r      <= CNT_W'(VAL_W);
            out_valid_r <= 1'b0;
            state_r     <= S_CONV;
          end else begin
            unique case (op_r)
              OP_CLEAR_ALL: begin
                for (int p = 0; p < NUM_DIGITS; p++) begin
                  dig_r[p] <= BLANK;
                end
                dot_r <= BLANK;
              end
              OP_CLEAR_DOTS: dot_r <= BLANK;
              OP_DOT: begin
                if (start_r < 3'(NUM_DIGITS)) begin
                  dot_r[start_r] <= (value_r == 32'd0);
                end
              end
              OP_NIBBLE, OP_BYTE, OP_HALFWORD: begin
                for (int p = 0; p < NUM_DIGITS; p++) begin
                  if (hex_wr[p]) begin
                    dig_r[p] <= hex_pat[p];
                  end
                end
              end
              default: ;
            endcase
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_CONV: begin
          out_valid_r <= 1'b0;
          bcd_r       <= shift_nxt[BCD_W+VAL_W-1 -: BCD_W];
          bin_r       <= shift_nxt[VAL_W-1:0];
          bits_r      <= bits_r - CNT_W'(1);
          if (bits_r == CNT_W'(1)) begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          for (int p = 0; p < NUM_DIGITS; p++) begin
            if (dec_wr[p]) begin
              dig_r[p] <= dec_pat[p];
              if (point_r != 3'd0) begin
                dot_r[p] <= dec_dot[p];
              end
            end
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  a_one_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted item did not make the block busy");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a command is still in progress");

  a_unused_dots_dark: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (dot_r[7:6] == 2'b11))
    else $error("dot beyond the last digit was lit");

  a_conv_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) |-> (bits_r != '0))
    else $error("BCD conversion ran past its bit count");

endmodule

`default_nettype wire
